### rtl/tsk_pkg.sv
// shared types, constants, micro-program and saturation helper for the kalman filter
`timescale 1ns / 1ps
`default_nettype none
package tsk_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int MAG_W     = WORD_W + FRAC_W + 1;
    localparam int DIV_STEPS = WORD_W + FRAC_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int PC_W      = 7;
    localparam int IDX_W     = 3;

    // program entry points
    localparam logic [PC_W-1:0] PC_PREDICT = PC_W'(0);
    localparam logic [PC_W-1:0] PC_UPDATE  = PC_W'(36);
    localparam logic [PC_W-1:0] PC_LOAD    = PC_W'(64);
    localparam logic [PC_W-1:0] PC_FINAL   = PC_W'(70);

    typedef enum logic [1:0] {
        OP_PREDICT = 2'd0,
        OP_UPDATE  = 2'd1,
        OP_LOAD    = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [IDX_W-1:0] {
        CFG_Q00 = 3'd0,
        CFG_Q01 = 3'd1,
        CFG_Q11 = 3'd2,
        CFG_R   = 3'd3,
        CFG_H0  = 3'd4,
        CFG_H1  = 3'd5,
        CFG_B0  = 3'd6,
        CFG_B1  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        U_MUL, U_ADD, U_SUB, U_DIV, U_SKZ, U_FIN, U_END
    } t_ucode;

    typedef enum logic [5:0] {
        S_ZERO,
        S_X0, S_X1, S_P00, S_P01, S_P11,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7,
        S_H0, S_H1, S_R, S_Q0, S_Q1, S_Q2, S_B0, S_B1,
        S_F00, S_F01, S_F10, S_F11, S_U, S_Z,
        S_I0, S_I1, S_I2, S_I3, S_I4
    } t_src;

    typedef struct packed {
        t_ucode code;
        t_src   dst;
        t_src   a;
        t_src   b;
    } t_uop;

    typedef struct packed {
        logic              sat;
        logic [WORD_W-1:0] val;
    } t_sat_res;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [WORD_W-1:0] quo;
    } t_div_res;

    // magnitude of a signed word, as unsigned
    function automatic logic [WORD_W-1:0] tsk_mag(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? WORD_W'(-v) : v;
    endfunction

    // clamp a signed magnitude into the word
    function automatic t_sat_res tsk_sat_mag(input logic neg, input logic [MAG_W-1:0] q);
        t_sat_res                r;
        logic     [MAG_W-1:0]    lim;
        lim = neg ? (MAG_W'(1) << (WORD_W - 1)) : ((MAG_W'(1) << (WORD_W - 1)) - MAG_W'(1));
        if (q > lim) begin
            r.sat = 1'b1;
            r.val = neg ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            r.sat = 1'b0;
            r.val = neg ? WORD_W'(-q[WORD_W-1:0]) : q[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic t_uop mk(input t_ucode c, input t_src d, input t_src a, input t_src b);
        t_uop u;
        u.code = c;
        u.dst  = d;
        u.a    = a;
        u.b    = b;
        return u;
    endfunction

    // micro-program: predict, update, load and the common tail
    function automatic t_uop tsk_uprog(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            // predict: state
            7'd0:  u = mk(U_MUL, S_T0, S_F00, S_X0);
            7'd1:  u = mk(U_MUL, S_T1, S_F01, S_X1);
            7'd2:  u = mk(U_ADD, S_T0, S_T0, S_T1);
            7'd3:  u = mk(U_MUL, S_T1, S_B0, S_U);
            7'd4:  u = mk(U_ADD, S_T2, S_T0, S_T1);
            7'd5:  u = mk(U_MUL, S_T0, S_F10, S_X0);
            7'd6:  u = mk(U_MUL, S_T1, S_F11, S_X1);
            7'd7:  u = mk(U_ADD, S_T0, S_T0, S_T1);
            7'd8:  u = mk(U_MUL, S_T1, S_B1, S_U);
            7'd9:  u = mk(U_ADD, S_X1, S_T0, S_T1);
            7'd10: u = mk(U_ADD, S_X0, S_T2, S_ZERO);
            // predict: f times p
            7'd11: u = mk(U_MUL, S_T0, S_F00, S_P00);
            7'd12: u = mk(U_MUL, S_T1, S_F01, S_P01);
            7'd13: u = mk(U_ADD, S_T2, S_T0, S_T1);
            7'd14: u = mk(U_MUL, S_T0, S_F00, S_P01);
            7'd15: u = mk(U_MUL, S_T1, S_F01, S_P11);
            7'd16: u = mk(U_ADD, S_T3, S_T0, S_T1);
            7'd17: u = mk(U_MUL, S_T0, S_F10, S_P00);
            7'd18: u = mk(U_MUL, S_T1, S_F11, S_P01);
            7'd19: u = mk(U_ADD, S_T4, S_T0, S_T1);
            7'd20: u = mk(U_MUL, S_T0, S_F10, S_P01);
            7'd21: u = mk(U_MUL, S_T1, S_F11, S_P11);
            7'd22: u = mk(U_ADD, S_T5, S_T0, S_T1);
            // predict: times f transposed plus process noise
            7'd23: u = mk(U_MUL, S_T0, S_T2, S_F00);
            7'd24: u = mk(U_MUL, S_T1, S_T3, S_F01);
            7'd25: u = mk(U_ADD, S_T0, S_T0, S_T1);
            7'd26: u = mk(U_ADD, S_P00, S_T0, S_Q0);
            7'd27: u = mk(U_MUL, S_T0, S_T2, S_F10);
            7'd28: u = mk(U_MUL, S_T1, S_T3, S_F11);
            7'd29: u = mk(U_ADD, S_T0, S_T0, S_T1);
            7'd30: u = mk(U_ADD, S_P01, S_T0, S_Q1);
            7'd31: u = mk(U_MUL, S_T0, S_T4, S_F10);
            7'd32: u = mk(U_MUL, S_T1, S_T5, S_F11);
            7'd33: u = mk(U_ADD, S_T0, S_T0, S_T1);
            7'd34: u = mk(U_ADD, S_P11, S_T0, S_Q2);
            7'd35: u = mk(U_FIN, S_ZERO, S_ZERO, S_ZERO);
            // update: innovation
            7'd36: u = mk(U_MUL, S_T0, S_H0, S_X0);
            7'd37: u = mk(U_MUL, S_T1, S_H1, S_X1);
            7'd38: u = mk(U_ADD, S_T0, S_T0, S_T1);
            7'd39: u = mk(U_SUB, S_T7, S_Z, S_T0);
            // update: p times h
            7'd40: u = mk(U_MUL, S_T0, S_P00, S_H0);
            7'd41: u = mk(U_MUL, S_T1, S_P01, S_H1);
            7'd42: u = mk(U_ADD, S_T2, S_T0, S_T1);
            7'd43: u = mk(U_MUL, S_T0, S_P01, S_H0);
            7'd44: u = mk(U_MUL, S_T1, S_P11, S_H1);
            7'd45: u = mk(U_ADD, S_T3, S_T0, S_T1);
            // update: innovation variance and gains
            7'd46: u = mk(U_MUL, S_T0, S_H0, S_T2);
            7'd47: u = mk(U_MUL, S_T1, S_H1, S_T3);
            7'd48: u = mk(U_ADD, S_T0, S_T0, S_T1);
            7'd49: u = mk(U_ADD, S_T4, S_T0, S_R);
            7'd50: u = mk(U_SKZ, S_ZERO, S_T4, S_ZERO);
            7'd51: u = mk(U_DIV, S_T5, S_T2, S_T4);
            7'd52: u = mk(U_DIV, S_T6, S_T3, S_T4);
            // update: correction
            7'd53: u = mk(U_MUL, S_T0, S_T5, S_T7);
            7'd54: u = mk(U_ADD, S_X0, S_X0, S_T0);
            7'd55: u = mk(U_MUL, S_T0, S_T6, S_T7);
            7'd56: u = mk(U_ADD, S_X1, S_X1, S_T0);
            7'd57: u = mk(U_MUL, S_T0, S_T5, S_T2);
            7'd58: u = mk(U_SUB, S_P00, S_P00, S_T0);
            7'd59: u = mk(U_MUL, S_T0, S_T5, S_T3);
            7'd60: u = mk(U_SUB, S_P01, S_P01, S_T0);
            7'd61: u = mk(U_MUL, S_T0, S_T6, S_T3);
            7'd62: u = mk(U_SUB, S_P11, S_P11, S_T0);
            7'd63: u = mk(U_FIN, S_ZERO, S_ZERO, S_ZERO);
            // load
            7'd64: u = mk(U_ADD, S_X0, S_I0, S_ZERO);
            7'd65: u = mk(U_ADD, S_X1, S_I1, S_ZERO);
            7'd66: u = mk(U_ADD, S_P00, S_I2, S_ZERO);
            7'd67: u = mk(U_ADD, S_P01, S_I3, S_ZERO);
            7'd68: u = mk(U_ADD, S_P11, S_I4, S_ZERO);
            7'd69: u = mk(U_FIN, S_ZERO, S_ZERO, S_ZERO);
            // common tail: predicted measurement
            7'd70: u = mk(U_MUL, S_T0, S_H0, S_X0);
            7'd71: u = mk(U_MUL, S_T1, S_H1, S_X1);
            7'd72: u = mk(U_ADD, S_T0, S_T0, S_T1);
            default: u = mk(U_END, S_ZERO, S_ZERO, S_ZERO);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

### rtl/tsk_if.sv
// handshake channels: input items, result items and register writes
`timescale 1ns / 1ps
`default_nettype none
interface tsk_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        operation;
    logic signed [tsk_pkg::WORD_W-1:0] trans_00;
    logic signed [tsk_pkg::WORD_W-1:0] trans_01;
    logic signed [tsk_pkg::WORD_W-1:0] trans_10;
    logic signed [tsk_pkg::WORD_W-1:0] trans_11;
    logic signed [tsk_pkg::WORD_W-1:0] ctrl_input;
    logic signed [tsk_pkg::WORD_W-1:0] measured;
    logic signed [tsk_pkg::WORD_W-1:0] init_first;
    logic signed [tsk_pkg::WORD_W-1:0] init_second;
    logic signed [tsk_pkg::WORD_W-1:0] init_cov_00;
    logic signed [tsk_pkg::WORD_W-1:0] init_cov_01;
    logic signed [tsk_pkg::WORD_W-1:0] init_cov_11;
    modport source (output valid, operation, trans_00, trans_01, trans_10, trans_11,
                    ctrl_input, measured, init_first, init_second, init_cov_00,
                    init_cov_01, init_cov_11, input ready);
    modport sink (input valid, operation, trans_00, trans_01, trans_10, trans_11,
                  ctrl_input, measured, init_first, init_second, init_cov_00,
                  init_cov_01, init_cov_11, output ready);
endinterface

interface tsk_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tsk_pkg::WORD_W-1:0] est_first;
    logic signed [tsk_pkg::WORD_W-1:0] est_second;
    logic signed [tsk_pkg::WORD_W-1:0] cov_00;
    logic signed [tsk_pkg::WORD_W-1:0] cov_01;
    logic signed [tsk_pkg::WORD_W-1:0] cov_11;
    logic signed [tsk_pkg::WORD_W-1:0] meas_estimate;
    logic                              update_applied;
    logic                              saturated;
    modport source (output valid, est_first, est_second, cov_00, cov_01, cov_11,
                    meas_estimate, update_applied, saturated, input ready);
    modport sink (input valid, est_first, est_second, cov_00, cov_01, cov_11,
                  meas_estimate, update_applied, saturated, output ready);
endinterface

interface tsk_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tsk_pkg::IDX_W-1:0]         addr;
    logic [tsk_pkg::WORD_W-1:0]        data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

### rtl/tsk_div.sv
// restoring divider for the gains: one quotient bit a cycle, rounded and saturated
`timescale 1ns / 1ps
`default_nettype none
module tsk_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [tsk_pkg::WORD_W-1:0] i_num,
    input  wire logic [tsk_pkg::WORD_W-1:0] i_den,
    output tsk_pkg::t_div_res               o_res
);
    import tsk_pkg::*;

    logic                      r_busy;
    logic                      r_fin;
    logic [DCNT_W-1:0]         r_cnt;
    logic [WORD_W-1:0]         r_rem;
    logic [DIV_STEPS-1:0]      r_num;
    logic [DIV_STEPS-1:0]      r_quo;
    logic [WORD_W-1:0]         r_den;
    logic                      r_neg;
    t_div_res                  r_res;

    logic [WORD_W:0]           trial;
    logic [WORD_W:0]           diff;
    logic                      ge;
    logic                      rnd_up;
    logic [MAG_W-1:0]          rq;
    t_sat_res                  fin_res;

    // trial subtract of one numerator bit
    assign trial   = {r_rem, r_num[DIV_STEPS-1]};
    assign diff    = trial - {1'b0, r_den};
    assign ge      = (trial >= {1'b0, r_den});
    // round half away from zero on the remainder
    assign rnd_up  = ({r_rem, 1'b0} >= {1'b0, r_den});
    assign rq      = {1'b0, r_quo} + MAG_W'(rnd_up);
    assign fin_res = tsk_sat_mag(r_neg, rq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_fin      <= 1'b0;
            r_res.done <= 1'b0;
        end else begin
            r_res.done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= '0;
                r_num  <= {tsk_mag(i_num), {FRAC_W{1'b0}}};
                r_den  <= tsk_mag(i_den);
                r_neg  <= i_num[WORD_W-1] ^ i_den[WORD_W-1];
            end else if (r_busy) begin
                r_rem <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
                r_num <= {r_num[DIV_STEPS-2:0], 1'b0};
                r_quo <= {r_quo[DIV_STEPS-2:0], ge};
                r_cnt <= r_cnt + DCNT_W'(1);
                if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin      <= 1'b0;
                r_res.done <= 1'b1;
                r_res.sat  <= fin_res.sat;
                r_res.quo  <= fin_res.val;
            end
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

### rtl/two_state_kalman_filter.sv
// two-state kalman filter top level: register file, micro-sequencer, shared multiplier and adder
// one item at a time; ready only while idle, result held until taken
// an item runs a micro-program: load, predict, or update with two bit-serial divisions;
// an update with zero innovation variance skips them; each multiply goes ST_RUN then ST_MUL
// the single shared multiplier, adder and bit-serial divider serve every micro-op
// synchronous active-low reset clears state to zero and registers to their defaults
`timescale 1ns / 1ps
`default_nettype none
module two_state_kalman_filter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tsk_in_if.sink     i_in,
    tsk_out_if.source  o_out,
    tsk_cfg_if.sink    i_cfg
);
    import tsk_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_MUL, ST_DIV, ST_OUT} t_state;

    t_state            r_state;
    logic [PC_W-1:0]   r_pc;

    // configuration registers
    logic [WORD_W-1:0] r_q00, r_q01, r_q11, r_r, r_h0, r_h1, r_b0, r_b1;
    // latched item fields
    logic [WORD_W-1:0] r_f00, r_f01, r_f10, r_f11, r_u, r_z;
    logic [WORD_W-1:0] r_i0, r_i1, r_i2, r_i3, r_i4;
    // filter state and scratch registers
    logic [WORD_W-1:0] r_x0, r_x1, r_p00, r_p01, r_p11;
    logic [WORD_W-1:0] r_t0, r_t1, r_t2, r_t3, r_t4, r_t5, r_t6, r_t7;
    // multiplier stage
    logic [2*WORD_W-1:0] r_prod;
    logic                r_mneg;
    // step flags and result
    logic              r_applied, r_sat;
    logic              r_ovalid;
    logic [WORD_W-1:0] r_o_x0, r_o_x1, r_o_p00, r_o_p01, r_o_p11, r_o_meas;
    logic              r_o_applied, r_o_sat;

    t_uop              uop;
    logic [WORD_W-1:0] a_val, b_val;
    logic [WORD_W:0]   sum;
    t_sat_res          add_res;
    logic [2*WORD_W:0] rnd;
    t_sat_res          mul_res;
    logic              div_start;
    t_div_res          div_res;
    logic              wb_en;
    t_src              wb_dst;
    logic [WORD_W-1:0] wb_val;
    logic              wb_sat;
    logic              in_acc;

    function automatic logic [WORD_W-1:0] sel(input t_src s);
        case (s)
            S_X0:    return r_x0;
            S_X1:    return r_x1;
            S_P00:   return r_p00;
            S_P01:   return r_p01;
            S_P11:   return r_p11;
            S_T0:    return r_t0;
            S_T1:    return r_t1;
            S_T2:    return r_t2;
            S_T3:    return r_t3;
            S_T4:    return r_t4;
            S_T5:    return r_t5;
            S_T6:    return r_t6;
            S_T7:    return r_t7;
            S_H0:    return r_h0;
            S_H1:    return r_h1;
            S_R:     return r_r;
            S_Q0:    return r_q00;
            S_Q1:    return r_q01;
            S_Q2:    return r_q11;
            S_B0:    return r_b0;
            S_B1:    return r_b1;
            S_F00:   return r_f00;
            S_F01:   return r_f01;
            S_F10:   return r_f10;
            S_F11:   return r_f11;
            S_U:     return r_u;
            S_Z:     return r_z;
            S_I0:    return r_i0;
            S_I1:    return r_i1;
            S_I2:    return r_i2;
            S_I3:    return r_i3;
            S_I4:    return r_i4;
            default: return '0;
        endcase
    endfunction

    // operand fetch
    assign uop   = tsk_uprog(r_pc);
    assign a_val = sel(uop.a);
    assign b_val = sel(uop.b);

    // saturating add or subtract
    always_comb begin
        if (uop.code == U_SUB) begin
            sum = {a_val[WORD_W-1], a_val} - {b_val[WORD_W-1], b_val};
        end else begin
            sum = {a_val[WORD_W-1], a_val} + {b_val[WORD_W-1], b_val};
        end
        if (sum[WORD_W] != sum[WORD_W-1]) begin
            add_res.sat = 1'b1;
            add_res.val = sum[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}}
                                      : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            add_res.sat = 1'b0;
            add_res.val = sum[WORD_W-1:0];
        end
    end

    // product rounding and saturation, written back in ST_MUL
    assign rnd     = {1'b0, r_prod} + ((2*WORD_W+1)'(1) << (FRAC_W - 1));
    assign mul_res = tsk_sat_mag(r_mneg, rnd[2*WORD_W:FRAC_W]);

    assign div_start = (r_state == ST_RUN) && (uop.code == U_DIV);

    tsk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (a_val),
        .i_den   (b_val),
        .o_res   (div_res)
    );

    // write-back select
    always_comb begin
        wb_en  = 1'b0;
        wb_dst = uop.dst;
        wb_val = add_res.val;
        wb_sat = 1'b0;
        case (r_state)
            ST_RUN: begin
                if (uop.code == U_ADD || uop.code == U_SUB) begin
                    wb_en  = 1'b1;
                    wb_sat = add_res.sat;
                end
            end
            ST_MUL: begin
                wb_en  = 1'b1;
                wb_val = mul_res.val;
                wb_sat = mul_res.sat;
            end
            ST_DIV: begin
                wb_en  = div_res.done;
                wb_val = div_res.quo;
                wb_sat = div_res.sat;
            end
            default: wb_en = 1'b0;
        endcase
    end

    assign in_acc = i_in.valid && (r_state == ST_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q00 <= '0;
            r_q01 <= '0;
            r_q11 <= '0;
            r_r   <= WORD_W'(1) << FRAC_W;
            r_h0  <= WORD_W'(1) << FRAC_W;
            r_h1  <= '0;
            r_b0  <= '0;
            r_b1  <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.addr))
                CFG_Q00: r_q00 <= i_cfg.data;
                CFG_Q01: r_q01 <= i_cfg.data;
                CFG_Q11: r_q11 <= i_cfg.data;
                CFG_R:   r_r   <= i_cfg.data;
                CFG_H0:  r_h0  <= i_cfg.data;
                CFG_H1:  r_h1  <= i_cfg.data;
                CFG_B0:  r_b0  <= i_cfg.data;
                CFG_B1:  r_b1  <= i_cfg.data;
                default: r_b1  <= r_b1;
            endcase
        end
    end

    // sequencer, state registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= '0;
            r_ovalid <= 1'b0;
            r_x0     <= '0;
            r_x1     <= '0;
            r_p00    <= '0;
            r_p01    <= '0;
            r_p11    <= '0;
        end else begin
            // register write-back
            if (wb_en) begin
                r_sat <= r_sat | wb_sat;
                case (wb_dst)
                    S_X0:    r_x0  <= wb_val;
                    S_X1:    r_x1  <= wb_val;
                    S_P00:   r_p00 <= wb_val;
                    S_P01:   r_p01 <= wb_val;
                    S_P11:   r_p11 <= wb_val;
                    S_T0:    r_t0  <= wb_val;
                    S_T1:    r_t1  <= wb_val;
                    S_T2:    r_t2  <= wb_val;
                    S_T3:    r_t3  <= wb_val;
                    S_T4:    r_t4  <= wb_val;
                    S_T5:    r_t5  <= wb_val;
                    S_T6:    r_t6  <= wb_val;
                    S_T7:    r_t7  <= wb_val;
                    default: r_t7  <= r_t7;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_f00     <= i_in.trans_00;
                        r_f01     <= i_in.trans_01;
                        r_f10     <= i_in.trans_10;
                        r_f11     <= i_in.trans_11;
                        r_u       <= i_in.ctrl_input;
                        r_z       <= i_in.measured;
                        r_i0      <= i_in.init_first;
                        r_i1      <= i_in.init_second;
                        r_i2      <= i_in.init_cov_00;
                        r_i3      <= i_in.init_cov_01;
                        r_i4      <= i_in.init_cov_11;
                        r_sat     <= 1'b0;
                        r_applied <= 1'b1;
                        r_state   <= ST_RUN;
                        case (t_opcode'(i_in.operation))
                            OP_PREDICT: r_pc <= PC_PREDICT;
                            OP_UPDATE:  r_pc <= PC_UPDATE;
                            OP_LOAD:    r_pc <= PC_LOAD;
                            default: begin
                                r_pc      <= PC_FINAL;
                                r_applied <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    case (uop.code)
                        U_MUL: begin
                            r_prod  <= tsk_mag(a_val) * tsk_mag(b_val);
                            r_mneg  <= a_val[WORD_W-1] ^ b_val[WORD_W-1];
                            r_state <= ST_MUL;
                        end
                        U_ADD, U_SUB: r_pc <= r_pc + PC_W'(1);
                        U_DIV:        r_state <= ST_DIV;
                        U_SKZ: begin
                            if (a_val == '0) begin
                                r_applied <= 1'b0;
                                r_pc      <= PC_FINAL;
                            end else begin
                                r_pc <= r_pc + PC_W'(1);
                            end
                        end
                        U_FIN: r_pc <= PC_FINAL;
                        default: begin
                            r_o_x0      <= r_x0;
                            r_o_x1      <= r_x1;
                            r_o_p00     <= r_p00;
                            r_o_p01     <= r_p01;
                            r_o_p11     <= r_p11;
                            r_o_meas    <= r_t0;
                            r_o_applied <= r_applied;
                            r_o_sat     <= r_sat;
                            r_ovalid    <= 1'b1;
                            r_state     <= ST_OUT;
                        end
                    endcase
                end
                ST_MUL: begin
                    r_pc    <= r_pc + PC_W'(1);
                    r_state <= ST_RUN;
                end
                ST_DIV: begin
                    if (div_res.done) begin
                        r_pc    <= r_pc + PC_W'(1);
                        r_state <= ST_RUN;
                    end
                end
                ST_OUT: begin
                    if (o_out.ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ports
    assign i_in.ready           = (r_state == ST_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_ovalid;
    assign o_out.est_first      = r_o_x0;
    assign o_out.est_second     = r_o_x1;
    assign o_out.cov_00         = r_o_p00;
    assign o_out.cov_01         = r_o_p01;
    assign o_out.cov_11         = r_o_p11;
    assign o_out.meas_estimate  = r_o_meas;
    assign o_out.update_applied = r_o_applied;
    assign o_out.saturated      = r_o_sat;

endmodule
`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the two-state kalman filter: directed table, then random phases
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import tsk_pkg::*;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] f00, f01, f10, f11, u, z, i0, i1, i2, i3, i4;
    } t_item;

    typedef struct packed {
        logic signed [31:0] est_first, est_second, cov_00, cov_01, cov_11, meas_estimate;
        logic               update_applied, saturated;
    } t_estimate;

    typedef struct packed {
        t_item     item;
        logic      typed;
        t_estimate want;
    } t_row;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam logic signed [31:0] ONE = 32'sd65536;
    localparam logic signed [31:0] PMAX = 32'sh7fffffff;
    localparam logic signed [31:0] PMIN = 32'sh80000000;

    logic i_clk;
    logic i_rst_n;
    tsk_in_if  in_if ();
    tsk_out_if out_if ();
    tsk_cfg_if cfg_if ();

    two_state_kalman_filter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // filter state and register copy kept by the predictor
    longint             st_x0, st_x1, st_p00, st_p01, st_p11;
    logic signed [31:0] regs [8];
    logic               sat_seen;
    t_estimate          pending_est [$];
    int                 n_errors;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 hold_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // fixed point arithmetic of the filter
    function automatic longint clamp_word(longint v);
        if (v > WMAX) begin
            sat_seen = 1'b1;
            return WMAX;
        end
        if (v < WMIN) begin
            sat_seen = 1'b1;
            return WMIN;
        end
        return v;
    endfunction

    function automatic longint q_add(longint a, longint b);
        return clamp_word(a + b);
    endfunction

    function automatic longint q_sub(longint a, longint b);
        return clamp_word(a - b);
    endfunction

    function automatic longint q_mul(longint a, longint b);
        longint p, m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = (m + 64'sd32768) >>> 16;
        return clamp_word((p < 0) ? -m : m);
    endfunction

    function automatic longint q_div(longint n, longint d);
        longint mn, md, q, r;
        mn = ((n < 0) ? -n : n) <<< 16;
        md = (d < 0) ? -d : d;
        q  = mn / md;
        r  = mn % md;
        if (2 * r >= md) q = q + 1;
        return clamp_word(((n < 0) != (d < 0)) ? -q : q);
    endfunction

    // one filter step on the predictor state
    function automatic t_estimate kalman_step(t_item it);
        t_estimate e;
        longint h0, h1, n0, n1, a00, a01, a10, a11, zh, y, ph0, ph1, s, k0, k1;
        sat_seen = 1'b0;
        e.update_applied = 1'b1;
        h0 = regs[CFG_H0];
        h1 = regs[CFG_H1];
        case (it.op)
            OP_PREDICT: begin
                n0  = q_add(q_add(q_mul(it.f00, st_x0), q_mul(it.f01, st_x1)),
                            q_mul(regs[CFG_B0], it.u));
                n1  = q_add(q_add(q_mul(it.f10, st_x0), q_mul(it.f11, st_x1)),
                            q_mul(regs[CFG_B1], it.u));
                a00 = q_add(q_mul(it.f00, st_p00), q_mul(it.f01, st_p01));
                a01 = q_add(q_mul(it.f00, st_p01), q_mul(it.f01, st_p11));
                a10 = q_add(q_mul(it.f10, st_p00), q_mul(it.f11, st_p01));
                a11 = q_add(q_mul(it.f10, st_p01), q_mul(it.f11, st_p11));
                st_x0  = n0;
                st_x1  = n1;
                st_p00 = q_add(q_add(q_mul(a00, it.f00), q_mul(a01, it.f01)), regs[CFG_Q00]);
                st_p01 = q_add(q_add(q_mul(a00, it.f10), q_mul(a01, it.f11)), regs[CFG_Q01]);
                st_p11 = q_add(q_add(q_mul(a10, it.f10), q_mul(a11, it.f11)), regs[CFG_Q11]);
            end
            OP_UPDATE: begin
                zh  = q_add(q_mul(h0, st_x0), q_mul(h1, st_x1));
                y   = q_sub(it.z, zh);
                ph0 = q_add(q_mul(st_p00, h0), q_mul(st_p01, h1));
                ph1 = q_add(q_mul(st_p01, h0), q_mul(st_p11, h1));
                s   = q_add(q_add(q_mul(h0, ph0), q_mul(h1, ph1)), regs[CFG_R]);
                // zero innovation variance: skip the correction
                if (s == 0) begin
                    e.update_applied = 1'b0;
                end else begin
                    k0     = q_div(ph0, s);
                    k1     = q_div(ph1, s);
                    st_x0  = q_add(st_x0, q_mul(k0, y));
                    st_x1  = q_add(st_x1, q_mul(k1, y));
                    st_p00 = q_sub(st_p00, q_mul(k0, ph0));
                    st_p01 = q_sub(st_p01, q_mul(k0, ph1));
                    st_p11 = q_sub(st_p11, q_mul(k1, ph1));
                end
            end
            OP_LOAD: begin
                st_x0  = it.i0;
                st_x1  = it.i1;
                st_p00 = it.i2;
                st_p01 = it.i3;
                st_p11 = it.i4;
            end
            default: e.update_applied = 1'b0;
        endcase
        zh = q_add(q_mul(h0, st_x0), q_mul(h1, st_x1));
        e.est_first     = st_x0[31:0];
        e.est_second    = st_x1[31:0];
        e.cov_00        = st_p00[31:0];
        e.cov_01        = st_p01[31:0];
        e.cov_11        = st_p11[31:0];
        e.meas_estimate = zh[31:0];
        e.saturated     = sat_seen;
        return e;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_estimate w;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_est.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                w = pending_est.pop_front();
                if (out_if.est_first !== w.est_first)
                    report_mismatch("est_first", out_if.est_first, w.est_first);
                if (out_if.est_second !== w.est_second)
                    report_mismatch("est_second", out_if.est_second, w.est_second);
                if (out_if.cov_00 !== w.cov_00)
                    report_mismatch("cov_00", out_if.cov_00, w.cov_00);
                if (out_if.cov_01 !== w.cov_01)
                    report_mismatch("cov_01", out_if.cov_01, w.cov_01);
                if (out_if.cov_11 !== w.cov_11)
                    report_mismatch("cov_11", out_if.cov_11, w.cov_11);
                if (out_if.meas_estimate !== w.meas_estimate)
                    report_mismatch("meas_estimate", out_if.meas_estimate, w.meas_estimate);
                if (out_if.update_applied !== w.update_applied)
                    report_mismatch("update_applied", out_if.update_applied, w.update_applied);
                if (out_if.saturated !== w.saturated)
                    report_mismatch("saturated", out_if.saturated, w.saturated);
            end
        end
    end

    // long hold-off counter
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(t_item it, logic typed, t_estimate want);
        t_estimate got;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid       <= 1'b1;
        in_if.operation   <= it.op;
        in_if.trans_00    <= it.f00;
        in_if.trans_01    <= it.f01;
        in_if.trans_10    <= it.f10;
        in_if.trans_11    <= it.f11;
        in_if.ctrl_input  <= it.u;
        in_if.measured    <= it.z;
        in_if.init_first  <= it.i0;
        in_if.init_second <= it.i1;
        in_if.init_cov_00 <= it.i2;
        in_if.init_cov_01 <= it.i3;
        in_if.init_cov_11 <= it.i4;
        do @(posedge i_clk); while (!in_if.ready);
        got = kalman_step(it);
        pending_est.push_back(typed ? want : got);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        regs[idx] = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // wait until every result is back and the block is idle
    task automatic drain;
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_est.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_item make_item(logic [1:0] op, logic signed [31:0] a,
                                        logic signed [31:0] b, logic signed [31:0] c,
                                        logic signed [31:0] d, logic signed [31:0] e);
        t_item it;
        it = '0;
        it.op = op;
        case (op)
            OP_PREDICT: begin
                it.f00 = a; it.f01 = b; it.f10 = c; it.f11 = d; it.u = e;
            end
            OP_UPDATE: it.z = a;
            OP_LOAD: begin
                it.i0 = a; it.i1 = b; it.i2 = c; it.i3 = d; it.i4 = e;
            end
            default: it.z = a;
        endcase
        return it;
    endfunction

    function automatic t_estimate make_est(logic signed [31:0] x0, logic signed [31:0] x1,
                                           logic signed [31:0] c0, logic signed [31:0] c1,
                                           logic signed [31:0] c2, logic signed [31:0] zh,
                                           logic ap, logic sat);
        t_estimate e;
        e.est_first = x0; e.est_second = x1;
        e.cov_00 = c0; e.cov_01 = c1; e.cov_11 = c2;
        e.meas_estimate = zh; e.update_applied = ap; e.saturated = sat;
        return e;
    endfunction

    // random word: mostly small Q16.16, sometimes wide or full range
    function automatic logic signed [31:0] rand_word();
        int r;
        r = $urandom_range(99);
        if (r < 55) return $signed($urandom_range(524288)) - 32'sd262144;
        if (r < 80) return $signed($urandom) >>> 8;
        return $urandom;
    endfunction

    function automatic logic signed [31:0] near(logic signed [31:0] base);
        return base + $signed($urandom_range(13108)) - 32'sd6554;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    r;
        it = '0;
        it.f00 = $urandom; it.f01 = $urandom; it.f10 = $urandom; it.f11 = $urandom;
        it.u = rand_word(); it.z = rand_word();
        it.i0 = rand_word(); it.i1 = rand_word();
        it.i2 = $urandom_range(262144); it.i3 = near(0); it.i4 = $urandom_range(262144);
        r = $urandom_range(99);
        if (r < 42) begin
            it.op = OP_PREDICT;
            // mostly a constant-velocity style transition
            if ($urandom_range(99) < 75) begin
                it.f00 = near(ONE); it.f01 = near(32'sd6554);
                it.f10 = near(0);   it.f11 = near(ONE);
            end
        end else if (r < 84) begin
            it.op = OP_UPDATE;
        end else if (r < 95) begin
            it.op = OP_LOAD;
            if ($urandom_range(99) < 20) begin
                it.i2 = $urandom; it.i3 = $urandom; it.i4 = $urandom;
            end
        end else begin
            it.op = OP_NOP;
        end
        return it;
    endfunction

    t_row              dir_rows [$];
    logic       [31:0] phase_regs [6][8];

    initial begin
        t_row row;
        n_errors       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        st_x0 = 0; st_x1 = 0; st_p00 = 0; st_p01 = 0; st_p11 = 0;
        foreach (regs[i]) regs[i] = '0;
        regs[CFG_R]  = ONE;
        regs[CFG_H0] = ONE;

        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.operation   = OP_NOP;
        in_if.trans_00    = '0;
        in_if.trans_01    = '0;
        in_if.trans_10    = '0;
        in_if.trans_11    = '0;
        in_if.ctrl_input  = '0;
        in_if.measured    = '0;
        in_if.init_first  = '0;
        in_if.init_second = '0;
        in_if.init_cov_00 = '0;
        in_if.init_cov_01 = '0;
        in_if.init_cov_11 = '0;
        out_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.addr       = CFG_Q00;
        cfg_if.data       = '0;

        // directed table
        row = '0;
        row.item = make_item(OP_PREDICT, ONE, 0, 0, ONE, 0);
        row.typed = 1'b1; row.want = make_est(0, 0, 0, 0, 0, 0, 1'b1, 1'b0);
        dir_rows.push_back(row);
        row.item = make_item(OP_LOAD, PMAX, PMIN, ONE, 0, ONE);
        row.want = make_est(PMAX, PMIN, ONE, 0, ONE, PMAX, 1'b1, 1'b0);
        dir_rows.push_back(row);
        row.item = make_item(OP_NOP, PMAX, 0, 0, 0, 0);
        row.want = make_est(PMAX, PMIN, ONE, 0, ONE, PMAX, 1'b0, 1'b0);
        dir_rows.push_back(row);
        row.item = make_item(OP_UPDATE, PMIN, 0, 0, 0, 0);
        row.typed = 1'b0;
        dir_rows.push_back(row);
        row.item = make_item(OP_LOAD, PMIN, PMAX, PMAX, PMIN, PMAX);
        row.typed = 1'b1; row.want = make_est(PMIN, PMAX, PMAX, PMIN, PMAX, PMIN, 1'b1, 1'b0);
        dir_rows.push_back(row);
        row.typed = 1'b0;
        row.item = make_item(OP_PREDICT, PMAX, PMAX, PMAX, PMAX, PMAX);
        dir_rows.push_back(row);
        row.item = make_item(OP_PREDICT, PMIN, PMIN, PMIN, PMIN, PMIN);
        dir_rows.push_back(row);
        row.item = make_item(OP_UPDATE, PMAX, 0, 0, 0, 0);
        dir_rows.push_back(row);
        // negative covariance cancels R: innovation variance zero, update skipped
        row.item = make_item(OP_LOAD, 32'sd196608, 32'sd131072, -ONE, 0, 0);
        row.typed = 1'b1;
        row.want = make_est(32'sd196608, 32'sd131072, -ONE, 0, 0, 32'sd196608, 1'b1, 1'b0);
        dir_rows.push_back(row);
        row.item = make_item(OP_UPDATE, ONE, 0, 0, 0, 0);
        row.want = make_est(32'sd196608, 32'sd131072, -ONE, 0, 0, 32'sd196608, 1'b0, 1'b0);
        dir_rows.push_back(row);
        row.typed = 1'b0;
        row.item = make_item(OP_LOAD, ONE, -ONE, 32'sd131072, 32'sd16384, 32'sd65536);
        dir_rows.push_back(row);
        row.item = make_item(OP_PREDICT, ONE, ONE, 0, ONE, PMAX);
        dir_rows.push_back(row);
        row.item = make_item(OP_UPDATE, 32'sd100000, 0, 0, 0, 0);
        dir_rows.push_back(row);
        row.item = make_item(OP_UPDATE, -32'sd70000, 0, 0, 0, 0);
        dir_rows.push_back(row);
        row.item = make_item(OP_PREDICT, 32'sd1, -32'sd1, 32'sd65535, -ONE, PMIN);
        dir_rows.push_back(row);

        // register settings per phase
        phase_regs[0] = '{32'd655, 32'd0, 32'd655, 32'd16384, ONE, 32'd0, 32'd32768, ONE};
        phase_regs[1] = '{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX};
        phase_regs[2] = '{PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN};
        phase_regs[3] = '{32'd0, 32'd0, 32'd0, 32'd0, ONE, 32'd32768, 32'd0, 32'd0};
        for (int k = 0; k < 8; k++) phase_regs[4][k] = near(k[0] ? 0 : ONE);
        phase_regs[5] = '{32'd0, 32'd0, 32'd0, ONE, ONE, 32'd0, 32'd0, 32'd0};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
        drain();

        // random phases with varying registers and idling
        for (int ph = 0; ph < 7; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (ph > 0) begin
                for (int k = 0; k < 8; k++) write_reg(t_cfg_idx'(k), phase_regs[ph - 1][k]);
            end
            for (int n = 0; n < 248; n++) begin
                if (ph == 1 && n == 20) hold_left = 600;
                send_item(rand_item(), 1'b0, '0);
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

### files.f
rtl/tsk_pkg.sv
rtl/tsk_if.sv
rtl/tsk_div.sv
rtl/two_state_kalman_filter.sv
tb/tb_top.sv
